// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PRI_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PRI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/pri_pkg.sv -----
package pri_pkg;

    localparam int SLOTS    = 64;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W    = 7;
    localparam int S_DATA_W = 288;
    localparam int M_DATA_W = 136;
    localparam int JIT_LIM  = 32768;

    typedef enum logic {
        OP_SPAWN = 1'b0,
        OP_TICK  = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SEL,
        ST_READ,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic signed [31:0] life;
        logic signed [31:0] vel_z;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } slot_t;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > 35'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -35'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [17:0] clamp_jit(input logic signed [20:0] v);
        logic signed [17:0] r;
        if (v > 21'(JIT_LIM)) begin
            r = 18'(JIT_LIM);
        end else if (v < -21'(JIT_LIM)) begin
            r = -18'(JIT_LIM);
        end else begin
            r = v[17:0];
        end
        return r;
    endfunction

endpackage

// ----- rtl/pri_ram.sv -----
module pri_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/particle_ring_integrator.sv -----
// Spawn item: written to the slot RAM at the head slot, no result.
// Tick item: update pass over all SLOTS slots (one slot read per cycle, 3-stage RMW pipe),
// then each live slot emitted via SEL, READ and HOLD, each dead slot skipped in SEL; items are
// taken one at a time, only while the block is idle (s_tready is high only in ST_IDLE).
// Reset clears control state and a per-slot written mask; unwritten slots read as zero.
`include "assert_macros.svh"

module particle_ring_integrator (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // origin_x, origin_y, origin_z, speed_x, speed_y, speed_z, init_life,
    // jitter_x, jitter_y, time_step, zero fill
    input  logic [pri_pkg::S_DATA_W-1:0]  s_tdata,
    // op
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pos_x, pos_y, pos_z, life_ratio, live_count, zero fill
    output logic [pri_pkg::M_DATA_W-1:0]  m_tdata,
    // valid_res
    output logic                          m_tuser,
    output logic                          m_tlast
);

    import pri_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    state_t state_reg, state_next;

    logic [IDX_W-1:0] head_reg, head_next;
    logic [SLOTS-1:0] written_reg;
    logic [16:0]      dt_reg;

    logic [IDX_W-1:0] rd_idx_reg;
    logic             issue_done_reg;
    logic [IDX_W-1:0] rd_addr_reg;
    logic             a_v_reg;
    logic [IDX_W-1:0] a_idx_reg;

    logic               b_v_reg;
    logic [IDX_W-1:0]   b_idx_reg;
    slot_t              b_slot_reg;
    logic signed [49:0] b_prod_x_reg, b_prod_y_reg, b_prod_z_reg;
    logic signed [31:0] b_life_reg;

    logic [SLOTS-1:0] live_mask_reg;
    logic [CNT_W-1:0] live_cnt_reg;
    logic [IDX_W-1:0] em_idx_reg;
    logic [CNT_W-1:0] emit_k_reg;

    logic signed [31:0] out_pos_x_reg, out_pos_y_reg, out_pos_z_reg;
    logic [31:0]        out_ratio_reg;
    logic               out_valid_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic               out_last_reg;

    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    slot_t            ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [$bits(slot_t)-1:0] ram_rdata;
    slot_t            ram_q;

    logic issue;
    logic spawn_acc;
    logic tick_acc;
    logic pass_done;
    logic emit_empty;
    logic emit_load;
    logic emit_next;

    logic signed [31:0] in_origin_x, in_origin_y, in_origin_z;
    logic signed [31:0] in_speed_x, in_speed_y, in_speed_z;
    logic [30:0]        in_init_life;
    logic signed [20:0] in_jitter_x, in_jitter_y;
    logic [16:0]        in_time_step;
    slot_t              spawn_slot;

    logic signed [17:0] dt_s;
    logic signed [49:0] prod_x, prod_y, prod_z;
    logic signed [31:0] life_a;
    slot_t              upd_slot;

    assign in_origin_x  = s_tdata[31:0];
    assign in_origin_y  = s_tdata[63:32];
    assign in_origin_z  = s_tdata[95:64];
    assign in_speed_x   = s_tdata[127:96];
    assign in_speed_y   = s_tdata[159:128];
    assign in_speed_z   = s_tdata[191:160];
    assign in_init_life = s_tdata[222:192];
    assign in_jitter_x  = s_tdata[243:223];
    assign in_jitter_y  = s_tdata[264:244];
    assign in_time_step = s_tdata[281:265];

    assign spawn_acc = s_tvalid && s_tready && (op_t'(s_tuser) == OP_SPAWN);
    assign tick_acc  = s_tvalid && s_tready && (op_t'(s_tuser) == OP_TICK);
    assign pass_done = b_v_reg && (b_idx_reg == LAST_IDX);
    assign issue     = (state_reg == ST_TICK) && !issue_done_reg;

    always_comb begin
        spawn_slot       = '0;
        spawn_slot.pos_x = sat32(35'(in_origin_x) + 35'(clamp_jit(in_jitter_x)));
        spawn_slot.pos_y = sat32(35'(in_origin_y) + 35'(clamp_jit(in_jitter_y)));
        spawn_slot.pos_z = in_origin_z;
        spawn_slot.vel_x = in_speed_x;
        spawn_slot.vel_y = in_speed_y;
        spawn_slot.vel_z = in_speed_z;
        spawn_slot.life  = $signed({1'b0, in_init_life});
    end

    assign head_next = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;

    // slot RAM; a slot never written reads as zero
    pri_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_q = written_reg[rd_addr_reg] ? slot_t'(ram_rdata) : '0;

    // stage A: products and life from the read slot
    assign dt_s   = $signed({1'b0, dt_reg});
    assign prod_x = ram_q.vel_x * dt_s;
    assign prod_y = ram_q.vel_y * dt_s;
    assign prod_z = ram_q.vel_z * dt_s;
    assign life_a = sat32(35'(ram_q.life) - 35'(dt_s));

    // stage B: floor shift, add, saturate, write back
    always_comb begin
        upd_slot       = b_slot_reg;
        upd_slot.pos_x = sat32(35'(b_slot_reg.pos_x) + 35'(b_prod_x_reg >>> 16));
        upd_slot.pos_y = sat32(35'(b_slot_reg.pos_y) + 35'(b_prod_y_reg >>> 16));
        upd_slot.pos_z = sat32(35'(b_slot_reg.pos_z) + 35'(b_prod_z_reg >>> 16));
        upd_slot.life  = b_life_reg;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = b_idx_reg;
        ram_wdata = upd_slot;
        if (spawn_acc) begin
            ram_we    = 1'b1;
            ram_waddr = head_reg;
            ram_wdata = spawn_slot;
        end else if (b_v_reg) begin
            ram_we = 1'b1;
        end
        ram_raddr = (state_reg == ST_TICK) ? rd_idx_reg : em_idx_reg;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (tick_acc) begin
                    state_next = ST_TICK;
                end
            end
            ST_TICK: begin
                if (pass_done) begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL: begin
                if (live_cnt_reg == '0) begin
                    state_next = ST_HOLD;
                end else if (live_mask_reg[em_idx_reg]) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_HOLD;
            end
            ST_HOLD: begin
                if (m_tready) begin
                    state_next = out_last_reg ? ST_IDLE : ST_SEL;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        emit_empty = 1'b0;
        emit_load  = 1'b0;
        emit_next  = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SEL: begin
                emit_empty = (live_cnt_reg == '0);
                emit_next  = (live_cnt_reg != '0) && !live_mask_reg[em_idx_reg];
            end
            ST_READ: begin
                emit_load = 1'b1;
            end
            ST_HOLD: begin
                m_tvalid  = 1'b1;
                emit_next = m_tready && !out_last_reg;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign m_tdata = {1'b0, out_cnt_reg, out_ratio_reg, out_pos_z_reg,
                      out_pos_y_reg, out_pos_x_reg};
    assign m_tuser = out_valid_reg;
    assign m_tlast = out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            head_reg       <= '0;
            written_reg    <= '0;
            rd_idx_reg     <= '0;
            issue_done_reg <= 1'b1;
            a_v_reg        <= 1'b0;
            b_v_reg        <= 1'b0;
            live_mask_reg  <= '0;
            live_cnt_reg   <= '0;
            em_idx_reg     <= '0;
            emit_k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            a_v_reg   <= issue;
            b_v_reg   <= a_v_reg;
            if (spawn_acc) begin
                head_reg <= head_next;
            end
            if (ram_we) begin
                written_reg[ram_waddr] <= 1'b1;
            end
            if (tick_acc) begin
                rd_idx_reg     <= '0;
                issue_done_reg <= 1'b0;
                live_cnt_reg   <= '0;
                em_idx_reg     <= '0;
                emit_k_reg     <= '0;
            end else if (issue) begin
                rd_idx_reg     <= rd_idx_reg + 1'b1;
                issue_done_reg <= (rd_idx_reg == LAST_IDX);
            end
            if (b_v_reg) begin
                live_mask_reg[b_idx_reg] <= (b_life_reg > 32'sd0);
                if (b_life_reg > 32'sd0) begin
                    live_cnt_reg <= live_cnt_reg + 1'b1;
                end
            end
            if (emit_next) begin
                em_idx_reg <= em_idx_reg + 1'b1;
                if (state_reg == ST_HOLD) begin
                    emit_k_reg <= emit_k_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_addr_reg <= ram_raddr;
        if (tick_acc) begin
            dt_reg <= in_time_step;
        end
        a_idx_reg    <= rd_idx_reg;
        b_idx_reg    <= a_idx_reg;
        b_slot_reg   <= ram_q;
        b_prod_x_reg <= prod_x;
        b_prod_y_reg <= prod_y;
        b_prod_z_reg <= prod_z;
        b_life_reg   <= life_a;
        if (emit_empty) begin
            out_pos_x_reg <= '0;
            out_pos_y_reg <= '0;
            out_pos_z_reg <= '0;
            out_ratio_reg <= '0;
            out_valid_reg <= 1'b0;
            out_cnt_reg   <= '0;
            out_last_reg  <= 1'b1;
        end else if (emit_load) begin
            out_pos_x_reg <= ram_q.pos_x;
            out_pos_y_reg <= ram_q.pos_y;
            out_pos_z_reg <= ram_q.pos_z;
            out_ratio_reg <= {ram_q.life[30:0], 1'b0};
            out_valid_reg <= 1'b1;
            out_cnt_reg   <= live_cnt_reg;
            out_last_reg  <= ((emit_k_reg + 1'b1) == live_cnt_reg);
        end
    end

    `PRI_ASSERT_SAME(a_no_accept_while_out, aclk, aresetn, s_tready, !m_tvalid,
        "input taken with result pending")
    `PRI_ASSERT_SAME(a_wb_in_tick, aclk, aresetn, b_v_reg, state_reg == ST_TICK,
        "write-back outside update pass")
    `PRI_ASSERT_SAME(a_empty_result, aclk, aresetn, m_tvalid && !m_tuser,
        m_tlast && (live_cnt_reg == '0), "empty result with live slots")
    `PRI_ASSERT_NEXT(a_last_to_idle, aclk, aresetn, m_tvalid && m_tready && m_tlast,
        s_tready, "not idle after last result")

endmodule
